// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the top-level RTL file of the sphere vertex generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/uvs_pkg.sv =====
// Package with constants, tables, types and rounding helpers of the sphere vertex generator.
package uvs_pkg;

    // Long division: 40 dividend bits, two quotient bits per stage.
    localparam int DIV_BITS   = 40;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    localparam int DIV_LANES  = 4;

    localparam logic [1:0] LANE_STACK  = 2'd0;
    localparam logic [1:0] LANE_SECTOR = 2'd1;
    localparam logic [1:0] LANE_TEX_U  = 2'd2;
    localparam logic [1:0] LANE_TEX_V  = 2'd3;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CW            = 34;
    localparam int ZW            = 33;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0]          EIGHTH_TURN  = 32'h2000_0000;

    localparam logic [31:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_STACKS  = 2'd1;
    localparam logic [1:0] REG_SECTORS = 2'd2;

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } t_vertex;

    // CORDIC output (Q4.30) to Q2.14, clamped to plus or minus one.
    function automatic logic signed [15:0] rnd_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [17:0]   s;
        t = v + 34'sd32768;
        s = t[CW-1:16];
        if (s > 18'sd16384)       rnd_q14 = 16'sd16384;
        else if (s < -18'sd16384) rnd_q14 = -16'sd16384;
        else                      rnd_q14 = s[15:0];
    endfunction

    // Product of two Q2.14 values back to Q2.14, clamped.
    function automatic logic signed [15:0] rnd_n14(input logic signed [31:0] v);
        logic signed [31:0] t;
        logic signed [17:0] s;
        t = v + 32'sd8192;
        s = t[31:14];
        if (s > 18'sd16384)       rnd_n14 = 16'sd16384;
        else if (s < -18'sd16384) rnd_n14 = -16'sd16384;
        else                      rnd_n14 = s[15:0];
    endfunction

    // Radius times a Q2.14 value to Q9.8, clamped.
    function automatic logic signed [16:0] rnd_p14(input logic signed [32:0] v);
        logic signed [32:0] t;
        logic signed [18:0] s;
        t = v + 33'sd8192;
        s = t[32:14];
        if (s > 19'sd65535)       rnd_p14 = 17'sd65535;
        else if (s < -19'sd65535) rnd_p14 = -17'sd65535;
        else                      rnd_p14 = s[16:0];
    endfunction

    // Radius times a Q4.28 product to Q9.8, clamped.
    function automatic logic signed [16:0] rnd_p28(input logic signed [48:0] v);
        logic signed [48:0] t;
        logic signed [20:0] s;
        t = v + 49'sd134217728;
        s = t[48:28];
        if (s > 21'sd65535)       rnd_p28 = 17'sd65535;
        else if (s < -21'sd65535) rnd_p28 = -17'sd65535;
        else                      rnd_p28 = s[16:0];
    endfunction

endpackage

// ===== hw/rtl/uv_sphere_vertex_generator_top.sv =====
// Top level of the UV sphere vertex generator: divider, CORDIC and multiplier pipeline.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+--------------------------------------
//  grid in   | input     | i_valid / o_stall  | i_stack_index, i_sector_index
//  vertex out| output    | o_valid / i_stall  | o_pos_*, o_normal_*, o_tex_u, o_tex_v
//  config    | input     | APB psel / penable | paddr, pwdata, prdata, pready
//
// One vertex per cycle is accepted while o_stall is low; the pipeline is made of the 20 stages of the
// radix-4 long division, the 16 CORDIC rotation stages and the multiply and rounding stages.
// A two-entry output buffer absorbs a stalled transfer; the pipeline holds while it is full.
// Reset is synchronous and active low; it clears the valid bits and loads register defaults.
module uv_sphere_vertex_generator_top
    import uvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_stack_index,
    input  logic [7:0]         i_sector_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
`include "assert_macros.svh"

    // ---------------- configuration ----------------
    logic [15:0] r_radius;
    logic [7:0]  r_stacks;
    logic [7:0]  r_sectors;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 16'd256;
            r_stacks  <= 8'd40;
            r_sectors <= 8'd80;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_RADIUS:  r_radius  <= pwdata[15:0];
                REG_STACKS:  r_stacks  <= pwdata[7:0];
                REG_SECTORS: r_sectors <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS:  prdata = {16'd0, r_radius};
            REG_STACKS:  prdata = {24'd0, r_stacks};
            REG_SECTORS: prdata = {24'd0, r_sectors};
            default:     prdata = 32'd0;
        endcase
    end

    // A count of zero acts as one.
    logic [7:0] n_st;
    logic [7:0] n_se;
    assign n_st = (r_stacks  == 8'd0) ? 8'd1 : r_stacks;
    assign n_se = (r_sectors == 8'd0) ? 8'd1 : r_sectors;

    // ---------------- flow control ----------------
    logic [1:0] r_cnt;
    logic       en;
    logic       push;
    logic       pop;

    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en;

    // ---------------- division stages ----------------
    logic             r_dv [0:DIV_STAGES];
    logic [DIV_BITS-1:0] r_dw [0:DIV_STAGES][0:DIV_LANES-1];
    logic [7:0]       r_dr [0:DIV_STAGES][0:DIV_LANES-1];
    logic [DIV_BITS-1:0] n_dw [1:DIV_STAGES][0:DIV_LANES-1];
    logic [7:0]       n_dr [1:DIV_STAGES][0:DIV_LANES-1];

    logic [7:0]          sat_i;
    logic [7:0]          sat_j;
    logic [DIV_BITS-1:0] half_st;
    logic [DIV_BITS-1:0] half_se;

    assign sat_i   = (i_stack_index  > n_st) ? n_st : i_stack_index;
    assign sat_j   = (i_sector_index > n_se) ? n_se : i_sector_index;
    assign half_st = {33'd0, n_st[7:1]};
    assign half_se = {33'd0, n_se[7:1]};

    // Dividend and quotient share one shift register per lane.
    always_comb begin
        logic [DIV_BITS-1:0] w;
        logic [7:0]          rem;
        logic [8:0]          t;
        logic [7:0]          dv;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                w   = r_dw[s-1][l];
                rem = r_dr[s-1][l];
                dv  = (l == int'(LANE_STACK) || l == int'(LANE_TEX_V)) ? n_st : n_se;
                for (int k = 0; k < DIV_STEP; k++) begin
                    t = {rem, w[DIV_BITS-1]};
                    w = {w[DIV_BITS-2:0], 1'b0};
                    if (t >= {1'b0, dv}) begin
                        t    = t - {1'b0, dv};
                        w[0] = 1'b1;
                    end
                    rem = t[7:0];
                end
                n_dw[s][l] = w;
                n_dr[s][l] = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= i_valid;
            for (int s = 1; s <= DIV_STAGES; s++) r_dv[s] <= r_dv[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dw[0][LANE_STACK]  <= {1'b0, sat_i, 31'd0} + half_st;
            r_dw[0][LANE_SECTOR] <= {sat_j, 32'd0} + half_se;
            r_dw[0][LANE_TEX_U]  <= {16'd0, sat_j, 16'd0} + half_se;
            r_dw[0][LANE_TEX_V]  <= {16'd0, sat_i, 16'd0} + half_st;
            for (int l = 0; l < DIV_LANES; l++) r_dr[0][l] <= 8'd0;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                for (int l = 0; l < DIV_LANES; l++) begin
                    r_dw[s][l] <= n_dw[s][l];
                    r_dr[s][l] <= n_dr[s][l];
                end
            end
        end
    end

    // ---------------- CORDIC stages (lane 0 stack angle, lane 1 sector angle) ----------------
    logic                 r_cv  [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_cx  [0:CORDIC_STAGES][0:1];
    logic signed [CW-1:0] r_cy  [0:CORDIC_STAGES][0:1];
    logic signed [ZW-1:0] r_cz  [0:CORDIC_STAGES][0:1];
    logic [1:0]           r_cq  [0:CORDIC_STAGES][0:1];
    logic [16:0]          r_ctu [0:CORDIC_STAGES];
    logic [16:0]          r_ctv [0:CORDIC_STAGES];

    logic [31:0] phase [0:1];
    logic [31:0] phq   [0:1];
    logic [31:0] resid [0:1];

    always_comb begin
        phase[0] = QUARTER_TURN - r_dw[DIV_STAGES][LANE_STACK][31:0];
        phase[1] = r_dw[DIV_STAGES][LANE_SECTOR][31:0];
        for (int l = 0; l < 2; l++) begin
            phq[l]   = phase[l] + EIGHTH_TURN;
            resid[l] = phase[l] - {phq[l][31:30], 30'd0};
        end
    end

    logic signed [CW-1:0] n_cx [1:CORDIC_STAGES][0:1];
    logic signed [CW-1:0] n_cy [1:CORDIC_STAGES][0:1];
    logic signed [ZW-1:0] n_cz [1:CORDIC_STAGES][0:1];

    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] at;
        for (int s = 1; s <= CORDIC_STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
                dx = r_cy[s-1][l] >>> (s - 1);
                dy = r_cx[s-1][l] >>> (s - 1);
                at = $signed({1'b0, ATAN_TURNS[s-1]});
                if (!r_cz[s-1][l][ZW-1]) begin
                    n_cx[s][l] = r_cx[s-1][l] - dx;
                    n_cy[s][l] = r_cy[s-1][l] + dy;
                    n_cz[s][l] = r_cz[s-1][l] - at;
                end else begin
                    n_cx[s][l] = r_cx[s-1][l] + dx;
                    n_cy[s][l] = r_cy[s-1][l] - dy;
                    n_cz[s][l] = r_cz[s-1][l] + at;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= CORDIC_STAGES; s++) r_cv[s] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_dv[DIV_STAGES];
            for (int s = 1; s <= CORDIC_STAGES; s++) r_cv[s] <= r_cv[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r_cx[0][l] <= CORDIC_GAIN;
                r_cy[0][l] <= '0;
                r_cz[0][l] <= {resid[l][31], resid[l]};
                r_cq[0][l] <= phq[l][31:30];
            end
            r_ctu[0] <= r_dw[DIV_STAGES][LANE_TEX_U][16:0];
            r_ctv[0] <= r_dw[DIV_STAGES][LANE_TEX_V][16:0];
            for (int s = 1; s <= CORDIC_STAGES; s++) begin
                for (int l = 0; l < 2; l++) begin
                    r_cx[s][l] <= n_cx[s][l];
                    r_cy[s][l] <= n_cy[s][l];
                    r_cz[s][l] <= n_cz[s][l];
                    r_cq[s][l] <= r_cq[s-1][l];
                end
                r_ctu[s] <= r_ctu[s-1];
                r_ctv[s] <= r_ctv[s-1];
            end
        end
    end

    // ---------------- quadrant fold and rounding to Q2.14 ----------------
    logic               r_pv;
    logic signed [15:0] r_pc [0:1];
    logic signed [15:0] r_ps [0:1];
    logic [16:0]        r_ptu;
    logic [16:0]        r_ptv;
    logic signed [CW-1:0] qc [0:1];
    logic signed [CW-1:0] qs [0:1];

    always_comb begin
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        for (int l = 0; l < 2; l++) begin
            x = r_cx[CORDIC_STAGES][l];
            y = r_cy[CORDIC_STAGES][l];
            case (r_cq[CORDIC_STAGES][l])
                2'd0:    begin qc[l] = x;  qs[l] = y;  end
                2'd1:    begin qc[l] = -y; qs[l] = x;  end
                2'd2:    begin qc[l] = -x; qs[l] = -y; end
                default: begin qc[l] = y;  qs[l] = -x; end
            endcase
        end
    end

    // ---------------- multiply stages ----------------
    logic               r_m1v;
    logic signed [31:0] r_mpc;
    logic signed [31:0] r_mps;
    logic signed [32:0] r_mpz;
    logic signed [15:0] r_msz;
    logic [16:0]        r_mtu;
    logic [16:0]        r_mtv;

    logic               r_m2v;
    logic signed [48:0] r_qx;
    logic signed [48:0] r_qy;
    logic signed [16:0] r_qz;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic signed [15:0] r_nz;
    logic [16:0]        r_qtu;
    logic [16:0]        r_qtv;

    logic signed [16:0] rad_s;
    assign rad_s = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
        end else if (en) begin
            r_pv  <= r_cv[CORDIC_STAGES];
            r_m1v <= r_pv;
            r_m2v <= r_m1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r_pc[l] <= rnd_q14(qc[l]);
                r_ps[l] <= rnd_q14(qs[l]);
            end
            r_ptu <= r_ctu[CORDIC_STAGES];
            r_ptv <= r_ctv[CORDIC_STAGES];

            r_mpc <= r_pc[0] * r_pc[1];
            r_mps <= r_pc[0] * r_ps[1];
            r_mpz <= rad_s * r_ps[0];
            r_msz <= r_ps[0];
            r_mtu <= r_ptu;
            r_mtv <= r_ptv;

            r_qx  <= rad_s * r_mpc;
            r_qy  <= rad_s * r_mps;
            r_qz  <= rnd_p14(r_mpz);
            r_nx  <= rnd_n14(r_mpc);
            r_ny  <= rnd_n14(r_mps);
            r_nz  <= r_msz;
            r_qtu <= r_mtu;
            r_qtv <= r_mtv;
        end
    end

    // ---------------- output buffer ----------------
    t_vertex r_fifo [0:1];
    logic    r_wp;
    logic    r_rp;
    t_vertex vtx;

    always_comb begin
        vtx.pos_x    = rnd_p28(r_qx);
        vtx.pos_y    = rnd_p28(r_qy);
        vtx.pos_z    = r_qz;
        vtx.normal_x = r_nx;
        vtx.normal_y = r_ny;
        vtx.normal_z = r_nz;
        vtx.tex_u    = r_qtu;
        vtx.tex_v    = r_qtv;
    end

    assign push = en && r_m2v;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_fifo[r_wp] <= vtx;
    end

    assign o_valid    = (r_cnt != 2'd0);
    assign o_pos_x    = r_fifo[r_rp].pos_x;
    assign o_pos_y    = r_fifo[r_rp].pos_y;
    assign o_pos_z    = r_fifo[r_rp].pos_z;
    assign o_normal_x = r_fifo[r_rp].normal_x;
    assign o_normal_y = r_fifo[r_rp].normal_y;
    assign o_normal_z = r_fifo[r_rp].normal_z;
    assign o_tex_u    = r_fifo[r_rp].tex_u;
    assign o_tex_v    = r_fifo[r_rp].tex_v;

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_cnt_range, r_cnt <= 2'd2)
    `ASSERT_NEXT(a_push_shows, push && r_cnt == 2'd0, o_valid)
    `ASSERT_IMPLY(a_tex_range, o_valid, o_tex_u <= 17'd65536 && o_tex_v <= 17'd65536)
    `ASSERT_IMPLY(a_nz_range, o_valid, o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384)

endmodule
